/* rtl/spatial_hash_grid_build_top_macros.svh */
// Assertion macros used by the grid build back end (shgb_back).
`ifndef SPATIAL_HASH_GRID_BUILD_TOP_MACROS_SVH
`define SPATIAL_HASH_GRID_BUILD_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SHGB_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("shgb assertion failed");
`define SHGB_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("shgb assertion failed");
`else
`define SHGB_ASSERT(label, clk, rst, prop)
`define SHGB_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

/* rtl/shgb_pkg.sv */
package shgb_pkg;

   localparam int POS_W         = 16;
   localparam int POS_FRAC_BITS = 14;
   localparam int AXIS_W        = 5;
   localparam int AXIS_MAX      = 16;
   localparam int SLOT_W        = 4;
   localparam int CT_REG_W      = 13;
   localparam int INV_W         = 7;
   localparam int CID_W         = 12;
   localparam int QRY_W         = 13;
   localparam int OP_W          = 3;
   localparam int STATUS_W      = 2;
   localparam int RANGE_W       = 14;
   localparam int PID_W         = 13;
   localparam int COUNT_W       = 14;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 13;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR  = 3'd0,
      OP_INSERT = 3'd1,
      OP_BUILD  = 3'd2,
      OP_LOOKUP = 3'd3,
      OP_READ   = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CELLS_X     = 3'd0,
      CSR_CELLS_Y     = 3'd1,
      CSR_CELLS_Z     = 3'd2,
      CSR_CELL_TOTAL  = 3'd3,
      CSR_INV_SPACING = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      F_IDLE, F_QUANT, F_MIX, F_CELL, F_PUSH
   } front_state_type;

   typedef enum logic [3:0] {
      B_SWEEP, B_IDLE, B_INS_WR, B_CNT_RD, B_CNT_B, B_CNT_WR, B_PF_RD, B_PF_WR,
      B_SC_RD, B_SC_B, B_SC_WR, B_LK1, B_LK2, B_RD
   } back_state_type;

   typedef enum logic [1:0] {
      SW_INIT, SW_CLEAR, SW_BUILD
   } sweep_type;

   // Configuration registers as seen by the datapath.
   typedef struct packed {
      logic [AXIS_W-1:0]   cells_x;
      logic [AXIS_W-1:0]   cells_y;
      logic [AXIS_W-1:0]   cells_z;
      logic [CT_REG_W-1:0] cell_total;
      logic [INV_W-1:0]    inv_spacing;
   } cfg_type;

   // One classified request on its way from the front to the back.
   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [CID_W-1:0] cid;
      logic [QRY_W-1:0] query;
   } job_type;

   // Limits an axis cell count to 1..16.
   function automatic logic [AXIS_W-1:0] sat_axis(input logic [AXIS_W-1:0] v);
      logic [AXIS_W-1:0] r;
      if (v == '0) begin
         r = AXIS_W'(1);
      end else if (v > AXIS_W'(AXIS_MAX)) begin
         r = AXIS_W'(AXIS_MAX);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

/* rtl/shgb_fifo.sv */
module shgb_fifo
   import shgb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    full,
   input  logic    pop,
   output job_type head,
   output logic    empty
);

   job_type     slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  fill_ff, fill_in;

   assign full  = (fill_ff == 2'd2);
   assign empty = (fill_ff == 2'd0);
   assign head  = slot_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      fill_in   = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/shgb_front.sv */
module shgb_front
   import shgb_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [OP_W-1:0]         req_type,
   input  logic signed [POS_W-1:0] req_pos_x,
   input  logic signed [POS_W-1:0] req_pos_y,
   input  logic signed [POS_W-1:0] req_pos_z,
   input  logic [QRY_W-1:0]        req_query_index,
   input  cfg_type                 cfg,
   input  logic                    init_busy,
   output logic                    push,
   output job_type                 push_data,
   input  logic                    fifo_full
);

   localparam int V_W  = POS_W + INV_W + 2;
   localparam int HALF = 2 ** (POS_FRAC_BITS - 1);
   localparam int T_W  = SLOT_W + AXIS_W;
   localparam int P_W  = T_W + AXIS_W;

   front_state_type          state_ff, state_in;
   logic [OP_W-1:0]          op_ff, op_in;
   logic signed [POS_W-1:0]  px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic [QRY_W-1:0]         q_ff, q_in;
   logic [SLOT_W-1:0]        sx_ff, sx_in, sy_ff, sy_in, sz_ff, sz_in;
   logic [T_W-1:0]           t_ff, t_in;
   logic [CID_W-1:0]         cid_ff, cid_in;
   logic [AXIS_W-1:0]        cx, cy, cz;
   logic [P_W-1:0]           prod;

   // Position to slot: floor((p + 0.5) * inv_spacing), limited to the axis.
   function automatic logic [SLOT_W-1:0] quantize(input logic signed [POS_W-1:0] p,
                                                  input logic [INV_W-1:0] inv,
                                                  input logic [AXIS_W-1:0] axis);
      logic signed [POS_W:0] biased;
      logic signed [V_W-1:0] v;
      logic [V_W-1:0]        slot_wide;
      logic [AXIS_W-1:0]     top;
      logic [SLOT_W-1:0]     r;
      biased    = $signed({p[POS_W-1], p}) + $signed((POS_W + 1)'(HALF));
      v         = biased * $signed({1'b0, inv});
      top       = axis - AXIS_W'(1);
      slot_wide = $unsigned(v) >> POS_FRAC_BITS;
      if (v[V_W-1]) begin
         r = '0;
      end else if (slot_wide > V_W'(top)) begin
         r = SLOT_W'(top);
      end else begin
         r = SLOT_W'(slot_wide);
      end
      return r;
   endfunction

   assign cx        = sat_axis(cfg.cells_x);
   assign cy        = sat_axis(cfg.cells_y);
   assign cz        = sat_axis(cfg.cells_z);
   assign req_stall = (state_ff != F_IDLE) || init_busy;
   assign prod      = P_W'(t_ff) * P_W'(cz);

   assign push_data.op    = op_ff;
   assign push_data.cid   = cid_ff;
   assign push_data.query = q_ff;

   // Request capture, three compute steps for the cell id, then the queue push.
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      pz_in    = pz_ff;
      q_in     = q_ff;
      sx_in    = sx_ff;
      sy_in    = sy_ff;
      sz_in    = sz_ff;
      t_in     = t_ff;
      cid_in   = cid_ff;
      push     = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            if (req_valid && !req_stall) begin
               op_in    = req_type;
               px_in    = req_pos_x;
               py_in    = req_pos_y;
               pz_in    = req_pos_z;
               q_in     = req_query_index;
               state_in = F_QUANT;
            end
         end
         F_QUANT: begin
            sx_in    = quantize(px_ff, cfg.inv_spacing, cx);
            sy_in    = quantize(py_ff, cfg.inv_spacing, cy);
            sz_in    = quantize(pz_ff, cfg.inv_spacing, cz);
            state_in = F_MIX;
         end
         F_MIX: begin
            t_in     = T_W'(sx_ff) * T_W'(cy) + T_W'(sy_ff);
            state_in = F_CELL;
         end
         F_CELL: begin
            cid_in   = CID_W'(prod + P_W'(sz_ff));
            state_in = F_PUSH;
         end
         F_PUSH: begin
            push = !fifo_full;
            if (!fifo_full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      px_ff  <= px_in;
      py_ff  <= py_in;
      pz_ff  <= pz_in;
      q_ff   <= q_in;
      sx_ff  <= sx_in;
      sy_ff  <= sy_in;
      sz_ff  <= sz_in;
      t_ff   <= t_in;
      cid_ff <= cid_in;
   end

endmodule

/* rtl/shgb_back.sv */
`include "spatial_hash_grid_build_top_macros.svh"

module shgb_back
   import shgb_pkg::*;
#(
   parameter int MAX_CELLS     = 4096,
   parameter int MAX_PARTICLES = 8192
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic [CT_REG_W-1:0] cell_total,
   output logic                pop,
   input  job_type             head,
   input  logic                empty,
   output logic                init_busy,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [CID_W-1:0]    rsp_cell_id,
   output logic [RANGE_W-1:0]  rsp_range_start,
   output logic [RANGE_W-1:0]  rsp_range_end,
   output logic [PID_W-1:0]    rsp_particle_id,
   output logic [COUNT_W-1:0]  rsp_particle_count
);

   localparam int PI_W = $clog2(MAX_PARTICLES);
   localparam int PC_W = $clog2(MAX_PARTICLES + 1);
   localparam int CI_W = $clog2(MAX_CELLS);
   localparam int BI_W = $clog2(MAX_CELLS + 1);
   localparam int BV_W = (PC_W + 1 > RANGE_W) ? PC_W + 1 : RANGE_W;

   // Memories.
   logic [BV_W-1:0]  bounds_mem [MAX_CELLS + 1];
   logic [CID_W-1:0] pcell_mem  [MAX_PARTICLES];
   logic [PI_W-1:0]  slist_mem  [MAX_PARTICLES];
   logic [PC_W-1:0]  cursor_mem [MAX_CELLS];

   logic             b_we;
   logic [BI_W-1:0]  b_wa, b_ra;
   logic [BV_W-1:0]  b_wd, b_rd_ff;
   logic             p_we;
   logic [PI_W-1:0]  p_wa, p_ra;
   logic [CID_W-1:0] p_wd, p_rd_ff;
   logic             s_we;
   logic [PI_W-1:0]  s_wa, s_ra;
   logic [PI_W-1:0]  s_wd, s_rd_ff;
   logic             c_we;
   logic [CI_W-1:0]  c_wa, c_ra;
   logic [PC_W-1:0]  c_wd, c_rd_ff;

   back_state_type   state_ff, state_in;
   sweep_type        mode_ff, mode_in;
   logic [BI_W-1:0]  idx_ff, idx_in;
   logic [PC_W-1:0]  p_ff, p_in;
   logic [PC_W-1:0]  count_ff, count_in;
   logic [BV_W-1:0]  acc_ff, acc_in;
   logic [BV_W-1:0]  rs_ff, rs_in;
   logic [CI_W-1:0]  bkt_ff, bkt_in;
   job_type          job_ff, job_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [CID_W-1:0]    rsp_cid_ff, rsp_cid_in;
   logic [RANGE_W-1:0]  rsp_rs_ff, rsp_rs_in;
   logic [RANGE_W-1:0]  rsp_re_ff, rsp_re_in;
   logic [PID_W-1:0]    rsp_pid_ff, rsp_pid_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic [BI_W-1:0]  ct;
   logic [CI_W-1:0]  head_bkt, prd_bkt;
   logic [BV_W-1:0]  sum;
   logic             last_p;

   // Cell id to bucket: ids beyond the cells in use fall into the last cell.
   function automatic logic [CI_W-1:0] bucket_of(input logic [CID_W-1:0] id,
                                                 input logic [BI_W-1:0] cells);
      logic [CI_W-1:0] r;
      if (32'(id) >= 32'(cells)) begin
         r = CI_W'(cells - BI_W'(1));
      end else begin
         r = CI_W'(id);
      end
      return r;
   endfunction

   // Cells in use, limited to 1..MAX_CELLS.
   always_comb begin
      if (cell_total == '0) begin
         ct = BI_W'(1);
      end else if (32'(cell_total) > MAX_CELLS) begin
         ct = BI_W'(MAX_CELLS);
      end else begin
         ct = BI_W'(cell_total);
      end
   end

   assign head_bkt  = bucket_of(head.cid, ct);
   assign prd_bkt   = bucket_of(p_rd_ff, ct);
   assign sum       = acc_ff + b_rd_ff;
   assign last_p    = (p_ff + PC_W'(1)) == count_ff;
   assign init_busy = (state_ff == B_SWEEP) && (mode_ff == SW_INIT);
   assign pop       = (state_ff == B_IDLE) && !empty && !rsp_valid_ff;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_cell_id        = rsp_cid_ff;
   assign rsp_range_start    = rsp_rs_ff;
   assign rsp_range_end      = rsp_re_ff;
   assign rsp_particle_id    = rsp_pid_ff;
   assign rsp_particle_count = rsp_count_ff;

   // Sequencer: one request at a time; memory reads are registered and answer in the next cycle.
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      idx_in        = idx_ff;
      p_in          = p_ff;
      count_in      = count_ff;
      acc_in        = acc_ff;
      rs_in         = rs_ff;
      bkt_in        = bkt_ff;
      job_in        = job_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_cid_in    = rsp_cid_ff;
      rsp_rs_in     = rsp_rs_ff;
      rsp_re_in     = rsp_re_ff;
      rsp_pid_in    = rsp_pid_ff;
      rsp_count_in  = rsp_count_ff;
      b_we = 1'b0; b_wa = '0; b_wd = '0; b_ra = '0;
      p_we = 1'b0; p_wa = '0; p_wd = '0; p_ra = '0;
      s_we = 1'b0; s_wa = '0; s_wd = '0; s_ra = '0;
      c_we = 1'b0; c_wa = '0; c_wd = '0; c_ra = '0;
      unique case (state_ff)
         B_SWEEP: begin
            b_we = 1'b1;
            b_wa = idx_ff;
            if (idx_ff == BI_W'(MAX_CELLS)) begin
               idx_in = '0;
               unique case (mode_ff)
                  SW_INIT: begin
                     state_in = B_IDLE;
                  end
                  SW_CLEAR: begin
                     count_in      = '0;
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_OK;
                     rsp_cid_in    = '0;
                     rsp_rs_in     = '0;
                     rsp_re_in     = '0;
                     rsp_pid_in    = '0;
                     rsp_count_in  = '0;
                     state_in      = B_IDLE;
                  end
                  SW_BUILD: begin
                     p_in   = '0;
                     acc_in = '0;
                     if (count_ff == '0) begin
                        idx_in   = BI_W'(1);
                        state_in = B_PF_RD;
                     end else begin
                        state_in = B_CNT_RD;
                     end
                  end
                  default: begin
                     state_in = B_IDLE;
                  end
               endcase
            end else begin
               idx_in = idx_ff + BI_W'(1);
            end
         end
         B_IDLE: begin
            if (pop) begin
               job_in        = head;
               rsp_status_in = ST_OK;
               rsp_cid_in    = '0;
               rsp_rs_in     = '0;
               rsp_re_in     = '0;
               rsp_pid_in    = '0;
               rsp_count_in  = COUNT_W'(count_ff);
               priority case (head.op)
                  OP_CLEAR: begin
                     mode_in  = SW_CLEAR;
                     idx_in   = '0;
                     state_in = B_SWEEP;
                  end
                  OP_INSERT: begin
                     if (32'(count_ff) >= MAX_PARTICLES) begin
                        rsp_status_in = ST_FULL;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        p_we     = 1'b1;
                        p_wa     = PI_W'(count_ff);
                        p_wd     = head.cid;
                        b_ra     = BI_W'(head_bkt) + BI_W'(1);
                        bkt_in   = head_bkt;
                        state_in = B_INS_WR;
                     end
                  end
                  OP_BUILD: begin
                     mode_in  = SW_BUILD;
                     idx_in   = '0;
                     state_in = B_SWEEP;
                  end
                  OP_LOOKUP: begin
                     if (32'(head.query) >= 32'(ct)) begin
                        rsp_status_in = ST_RANGE;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        b_ra     = BI_W'(head.query);
                        state_in = B_LK1;
                     end
                  end
                  OP_READ: begin
                     if (32'(head.query) >= 32'(count_ff)) begin
                        rsp_status_in = ST_RANGE;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        s_ra     = PI_W'(head.query);
                        state_in = B_RD;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         B_INS_WR: begin
            b_we         = 1'b1;
            b_wa         = BI_W'(bkt_ff) + BI_W'(1);
            b_wd         = b_rd_ff + BV_W'(1);
            count_in     = count_ff + PC_W'(1);
            rsp_cid_in   = job_ff.cid;
            rsp_count_in = COUNT_W'(count_ff + PC_W'(1));
            rsp_valid_in = 1'b1;
            state_in     = B_IDLE;
         end
         B_CNT_RD: begin
            p_ra     = PI_W'(p_ff);
            state_in = B_CNT_B;
         end
         B_CNT_B: begin
            bkt_in   = prd_bkt;
            b_ra     = BI_W'(prd_bkt) + BI_W'(1);
            state_in = B_CNT_WR;
         end
         B_CNT_WR: begin
            b_we = 1'b1;
            b_wa = BI_W'(bkt_ff) + BI_W'(1);
            b_wd = b_rd_ff + BV_W'(1);
            p_in = p_ff + PC_W'(1);
            if (last_p) begin
               idx_in   = BI_W'(1);
               acc_in   = '0;
               state_in = B_PF_RD;
            end else begin
               state_in = B_CNT_RD;
            end
         end
         B_PF_RD: begin
            b_ra     = idx_ff;
            state_in = B_PF_WR;
         end
         B_PF_WR: begin
            // Running sum becomes the bound; the previous sum seeds the cursor.
            b_we   = 1'b1;
            b_wa   = idx_ff;
            b_wd   = sum;
            c_we   = 1'b1;
            c_wa   = CI_W'(idx_ff - BI_W'(1));
            c_wd   = PC_W'(acc_ff);
            acc_in = sum;
            if (idx_ff == ct) begin
               p_in = '0;
               if (count_ff == '0) begin
                  rsp_status_in = ST_OK;
                  rsp_cid_in    = '0;
                  rsp_rs_in     = '0;
                  rsp_re_in     = '0;
                  rsp_pid_in    = '0;
                  rsp_count_in  = COUNT_W'(count_ff);
                  rsp_valid_in  = 1'b1;
                  state_in      = B_IDLE;
               end else begin
                  state_in = B_SC_RD;
               end
            end else begin
               idx_in   = idx_ff + BI_W'(1);
               state_in = B_PF_RD;
            end
         end
         B_SC_RD: begin
            p_ra     = PI_W'(p_ff);
            state_in = B_SC_B;
         end
         B_SC_B: begin
            bkt_in   = prd_bkt;
            c_ra     = prd_bkt;
            state_in = B_SC_WR;
         end
         B_SC_WR: begin
            s_we = 1'b1;
            s_wa = PI_W'(c_rd_ff);
            s_wd = PI_W'(p_ff);
            c_we = 1'b1;
            c_wa = bkt_ff;
            c_wd = c_rd_ff + PC_W'(1);
            p_in = p_ff + PC_W'(1);
            if (last_p) begin
               rsp_status_in = ST_OK;
               rsp_cid_in    = '0;
               rsp_rs_in     = '0;
               rsp_re_in     = '0;
               rsp_pid_in    = '0;
               rsp_count_in  = COUNT_W'(count_ff);
               rsp_valid_in  = 1'b1;
               state_in      = B_IDLE;
            end else begin
               state_in = B_SC_RD;
            end
         end
         B_LK1: begin
            rs_in    = b_rd_ff;
            b_ra     = BI_W'(job_ff.query) + BI_W'(1);
            state_in = B_LK2;
         end
         B_LK2: begin
            rsp_rs_in    = RANGE_W'(rs_ff);
            rsp_re_in    = RANGE_W'(b_rd_ff);
            rsp_valid_in = 1'b1;
            state_in     = B_IDLE;
         end
         B_RD: begin
            rsp_pid_in   = PID_W'(s_rd_ff);
            rsp_valid_in = 1'b1;
            state_in     = B_IDLE;
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_SWEEP;
         mode_ff      <= SW_INIT;
         idx_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff          <= p_in;
      acc_ff        <= acc_in;
      rs_ff         <= rs_in;
      bkt_ff        <= bkt_in;
      job_ff        <= job_in;
      rsp_status_ff <= rsp_status_in;
      rsp_cid_ff    <= rsp_cid_in;
      rsp_rs_ff     <= rsp_rs_in;
      rsp_re_ff     <= rsp_re_in;
      rsp_pid_ff    <= rsp_pid_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // Bucket bounds memory.
   always_ff @(posedge clock) begin
      if (b_we) begin
         bounds_mem[b_wa] <= b_wd;
      end
      b_rd_ff <= bounds_mem[b_ra];
   end

   // Per-particle cell memory.
   always_ff @(posedge clock) begin
      if (p_we) begin
         pcell_mem[p_wa] <= p_wd;
      end
      p_rd_ff <= pcell_mem[p_ra];
   end

   // Sorted list memory.
   always_ff @(posedge clock) begin
      if (s_we) begin
         slist_mem[s_wa] <= s_wd;
      end
      s_rd_ff <= slist_mem[s_ra];
   end

   // Scatter cursor memory.
   always_ff @(posedge clock) begin
      if (c_we) begin
         cursor_mem[c_wa] <= c_wd;
      end
      c_rd_ff <= cursor_mem[c_ra];
   end

   // A new request starts only with the result register free.
   `SHGB_ASSERT(a_pop_free, clock, reset, pop |-> !rsp_valid_ff)
   // The particle count never passes the store size.
   `SHGB_ASSERT(a_count_max, clock, reset, 32'(count_ff) <= MAX_PARTICLES)
   // An insert in its write state raises its result and returns to idle in the next cycle.
   `SHGB_ASSERT(a_ins_rsp, clock, reset,
                (state_ff == B_INS_WR) |=> (rsp_valid_ff && state_ff == B_IDLE))
   // The count changes only on insert completion or a finished clear.
   `SHGB_ASSERT(a_count_src, clock, reset,
                (count_ff != count_in) |-> (state_ff == B_INS_WR || state_ff == B_SWEEP))

endmodule

/* rtl/spatial_hash_grid_build_top.sv */
// Uniform-grid particle bucket table, built by counting sort.
// Requests arrive on the req_ channel (valid/stall); each one gives exactly
// one result on the rsp_ channel, in order. Request types: clear, insert,
// build, cell lookup and list read. Registers must be written on the csr_
// port only while the block is idle; the block itself does not enforce this.
// A request passes through the front in order: capture, quantize, two cell id
// steps and the queue push, which waits while the queue is full. The front
// takes no new request until it has pushed the last one. The back sequencer
// then runs each request against the memories. Clear is a zeroing sweep of
// the bucket bounds. Build runs a zeroing sweep, a count pass over the
// particles, a prefix pass over the cells in use and a scatter pass over the
// particles; with no particles the count and scatter passes are skipped. The
// two-entry queue lets the front take a new request while the back works or
// while a result waits; the result stays in its output register until the
// receiver drops rsp_stall.
// After reset a sweep clears every bucket bound; req_stall is high during
// that sweep. Configuration returns to 16x16x16 cells, 4096 cells in use
// and inv_spacing 15.
module spatial_hash_grid_build_top
   import shgb_pkg::*;
#(
   parameter int MAX_CELLS     = 4096,
   parameter int MAX_PARTICLES = 8192
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [OP_W-1:0]         req_type,
   input  logic signed [POS_W-1:0] req_pos_x,
   input  logic signed [POS_W-1:0] req_pos_y,
   input  logic signed [POS_W-1:0] req_pos_z,
   input  logic [QRY_W-1:0]        req_query_index,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [STATUS_W-1:0]     rsp_status,
   output logic [CID_W-1:0]        rsp_cell_id,
   output logic [RANGE_W-1:0]      rsp_range_start,
   output logic [RANGE_W-1:0]      rsp_range_end,
   output logic [PID_W-1:0]        rsp_particle_id,
   output logic [COUNT_W-1:0]      rsp_particle_count,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   logic    push, pop, fifo_full, fifo_empty, init_busy;
   job_type push_data, head;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_CELLS_X:     cfg_in.cells_x     = AXIS_W'(csr_wdata);
            CSR_CELLS_Y:     cfg_in.cells_y     = AXIS_W'(csr_wdata);
            CSR_CELLS_Z:     cfg_in.cells_z     = AXIS_W'(csr_wdata);
            CSR_CELL_TOTAL:  cfg_in.cell_total  = CT_REG_W'(csr_wdata);
            CSR_INV_SPACING: cfg_in.inv_spacing = INV_W'(csr_wdata);
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cells_x     <= AXIS_W'(16);
         cfg_ff.cells_y     <= AXIS_W'(16);
         cfg_ff.cells_z     <= AXIS_W'(16);
         cfg_ff.cell_total  <= CT_REG_W'(4096);
         cfg_ff.inv_spacing <= INV_W'(15);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   shgb_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_pos_z       (req_pos_z),
      .req_query_index (req_query_index),
      .cfg             (cfg_ff),
      .init_busy       (init_busy),
      .push            (push),
      .push_data       (push_data),
      .fifo_full       (fifo_full)
   );

   shgb_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (fifo_full),
      .pop       (pop),
      .head      (head),
      .empty     (fifo_empty)
   );

   shgb_back #(
      .MAX_CELLS     (MAX_CELLS),
      .MAX_PARTICLES (MAX_PARTICLES)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cell_total         (cfg_ff.cell_total),
      .pop                (pop),
      .head               (head),
      .empty              (fifo_empty),
      .init_busy          (init_busy),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_cell_id        (rsp_cell_id),
      .rsp_range_start    (rsp_range_start),
      .rsp_range_end      (rsp_range_end),
      .rsp_particle_id    (rsp_particle_id),
      .rsp_particle_count (rsp_particle_count)
   );

endmodule
